### rtl/dhot_pkg.sv
// Shared constants, payload types and config helpers for the double hash table.
`default_nettype none
package dhot_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int KEY_W       = 31;
  localparam int OUT_BKT_W   = 6;
  localparam int COLL_W      = 7;
  // Bucket numbers stay below min(TABLE_DEPTH, 2**CFG_W).
  localparam int BKT_W       = (IDX_W < CFG_W) ? IDX_W : CFG_W;
  localparam int SUM_W       = CFG_W + 1;
  localparam int JOBQ_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_PRIME = 1'd1;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST  = 7'd64;
  localparam logic [CFG_W-1:0] PROBE_PRIME_RST = 7'd61;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic [OUT_BKT_W-1:0] bucket;
    logic [COLL_W-1:0]    collisions;
    logic [KEY_W-1:0]     found_key;
  } out_item_t;

  // Classified operation handed from the hash front end to the probe engine.
  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] start;
    logic [BKT_W-1:0] stride;
  } job_t;

  typedef struct packed {
    logic [CFG_W-1:0] size;
    logic [CFG_W-1:0] prime;
  } cfg_t;

  function automatic logic [CFG_W-1:0] live_size(input logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] r;
    if (s == '0) begin
      r = CFG_W'(1);
    end else if (32'(s) > TABLE_DEPTH) begin
      r = CFG_W'(TABLE_DEPTH);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] live_prime(input logic [CFG_W-1:0] p);
    return (p == '0) ? CFG_W'(1) : p;
  endfunction

endpackage
`default_nettype wire

### rtl/dhot_job_fifo.sv
// Two-entry queue of classified jobs between the hash front end and the probe engine.
`default_nettype none
module dhot_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dhot_pkg::job_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output dhot_pkg::job_t     rdata_o
);

  localparam int PTR_W = (dhot_pkg::JOBQ_DEPTH > 1) ? $clog2(dhot_pkg::JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(dhot_pkg::JOBQ_DEPTH + 1);

  dhot_pkg::job_t entry_q [dhot_pkg::JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(dhot_pkg::JOBQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == dhot_pkg::JOBQ_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == dhot_pkg::JOBQ_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### rtl/dhot_front.sv
// Hash front end: takes one input beat and works out start bucket and probe stride.
`default_nettype none
module dhot_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dhot_pkg::cfg_t    cfg_i,
  input  wire logic              start_i,
  input  wire dhot_pkg::in_item_t item_i,
  output logic                   busy_o,
  output logic                   job_push_o,
  output dhot_pkg::job_t         job_o,
  input  wire logic              job_full_i
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_KEY  = 2'd1;
  localparam logic [1:0] FS_STEP = 2'd2;
  localparam logic [1:0] FS_PUSH = 2'd3;

  localparam int CNT_W = $clog2(dhot_pkg::KEY_W);
  localparam int PAD_W = dhot_pkg::KEY_W - dhot_pkg::CFG_W;

  logic [1:0]                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [dhot_pkg::KEY_W-1:0]    dvd_q, dvd_d;
  logic [dhot_pkg::CFG_W-1:0]    rs_q, rs_d, rp_q, rp_d;
  logic [dhot_pkg::BKT_W-1:0]    start_q, start_d, stride_q, stride_d;
  logic                          kind_q, kind_d;
  logic [dhot_pkg::KEY_W-1:0]    key_q, key_d;

  logic [dhot_pkg::CFG_W-1:0]    size, prime;
  logic [dhot_pkg::SUM_W-1:0]    ts, tp;
  logic [dhot_pkg::CFG_W-1:0]    rs_nx, rp_nx;

  assign size  = dhot_pkg::live_size(cfg_i.size);
  assign prime = dhot_pkg::live_prime(cfg_i.prime);

  // One restoring remainder step per cycle for both divisors.
  always_comb begin
    ts = {rs_q, dvd_q[dhot_pkg::KEY_W-1]};
    tp = {rp_q, dvd_q[dhot_pkg::KEY_W-1]};
    if (ts >= {1'b0, size}) begin
      ts = ts - {1'b0, size};
    end
    if (tp >= {1'b0, prime}) begin
      tp = tp - {1'b0, prime};
    end
    rs_nx = ts[dhot_pkg::CFG_W-1:0];
    rp_nx = tp[dhot_pkg::CFG_W-1:0];
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    rs_d     = rs_q;
    rp_d     = rp_q;
    start_d  = start_q;
    stride_d = stride_q;
    kind_d   = kind_q;
    key_d    = key_q;
    unique case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          kind_d  = item_i.kind;
          key_d   = item_i.key;
          dvd_d   = item_i.key;
          rs_d    = '0;
          rp_d    = '0;
          cnt_d   = '0;
          state_d = FS_KEY;
        end
      end
      FS_KEY: begin
        rs_d  = rs_nx;
        rp_d  = rp_nx;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (32'(cnt_q) == dhot_pkg::KEY_W - 1) begin
          state_d = FS_STEP;
          start_d = rs_nx[dhot_pkg::BKT_W-1:0];
          cnt_d   = '0;
          rs_d    = '0;
          // Second pass reduces the stride modulo the table size.
          dvd_d   = {(prime - rp_nx), {PAD_W{1'b0}}};
        end
      end
      FS_STEP: begin
        rs_d  = rs_nx;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (32'(cnt_q) == dhot_pkg::CFG_W - 1) begin
          stride_d = rs_nx[dhot_pkg::BKT_W-1:0];
          state_d  = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!job_full_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign busy_o       = (state_q != FS_IDLE);
  assign job_push_o   = (state_q == FS_PUSH);
  assign job_o.kind   = kind_q;
  assign job_o.key    = key_q;
  assign job_o.start  = start_q;
  assign job_o.stride = stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rs_q     <= rs_d;
    rp_q     <= rp_d;
    start_q  <= start_d;
    stride_q <= stride_d;
    kind_q   <= kind_d;
    key_q    <= key_d;
  end

endmodule
`default_nettype wire

### rtl/dhot_back.sv
// Probe engine: owns the bucket memory, walks the probe path and holds the result beat.
`default_nettype none
module dhot_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dhot_pkg::cfg_t  cfg_i,
  input  wire logic            job_empty_i,
  input  wire dhot_pkg::job_t  job_i,
  output logic                 job_pop_o,
  output logic                 clearing_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output dhot_pkg::out_item_t  res_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  localparam int BKT_W = dhot_pkg::BKT_W;
  localparam int IDX_W = dhot_pkg::IDX_W;
  localparam int SUM_W = dhot_pkg::SUM_W;
  localparam int CFG_W = dhot_pkg::CFG_W;
  localparam int KEY_W = dhot_pkg::KEY_W;

  logic [KEY_W-1:0] mem [dhot_pkg::TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  dhot_pkg::job_t      job_q, job_d;
  logic [BKT_W-1:0]    cur_q, cur_d;
  logic [CFG_W-1:0]    idx_q, idx_d;
  logic                res_valid_q, res_valid_d;
  dhot_pkg::out_item_t res_q, res_d;

  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [KEY_W-1:0]    wr_data;

  logic [CFG_W-1:0]    size;
  logic [SUM_W-1:0]    sum;
  logic [BKT_W-1:0]    next_b;
  logic                slot_free, hit_empty, hit_key, last, finish, ok, is_ins;

  assign size      = dhot_pkg::live_size(cfg_i.size);
  assign slot_free = !res_valid_q || pop_i;
  assign hit_empty = (rd_data_q == '0);
  assign hit_key   = (rd_data_q == job_q.key);
  assign last      = (idx_q == size - CFG_W'(1));
  assign is_ins    = (job_q.kind == dhot_pkg::KIND_INSERT);
  assign finish    = is_ins ? (hit_empty || last) : (hit_empty || hit_key || last);
  assign ok        = is_ins ? hit_empty : (!hit_empty && hit_key);

  // Both operands are below the size, so one conditional subtract wraps the sum.
  always_comb begin
    sum = SUM_W'(cur_q) + SUM_W'(job_q.stride);
    if (sum >= SUM_W'(size)) begin
      sum = sum - SUM_W'(size);
    end
    next_b = sum[BKT_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    job_d       = job_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = IDX_W'(cur_q);
    wr_en       = 1'b0;
    wr_addr     = IDX_W'(cur_q);
    wr_data     = job_q.key;
    job_pop_o   = 1'b0;
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + IDX_W'(1);
        if (32'(clr_q) == dhot_pkg::TABLE_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          cur_d     = job_i.start;
          idx_d     = '0;
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(job_i.start);
          state_d   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (finish) begin
          if (slot_free) begin
            res_valid_d      = 1'b1;
            res_d.status     = ok ? dhot_pkg::STATUS_OK : dhot_pkg::STATUS_FAIL;
            res_d.bucket     = ok ? dhot_pkg::OUT_BKT_W'(cur_q) : '0;
            res_d.collisions = (ok && is_ins) ? dhot_pkg::COLL_W'(idx_q) : '0;
            res_d.found_key  = (ok && !is_ins) ? job_q.key : '0;
            wr_en            = ok && is_ins;
            state_d          = ST_IDLE;
          end
        end else begin
          cur_d   = next_b;
          idx_d   = idx_q + CFG_W'(1);
          rd_en   = 1'b1;
          rd_addr = IDX_W'(next_b);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign empty_o    = !res_valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    cur_q <= cur_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/double_hash_open_address_table_top.sv
// Top level of the double hash open address table: config registers and part wiring.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------------------------------------
//   input    | push / full      | in_item_i  (kind, key)
//   result   | pop / empty      | res_o      (status, bucket, collisions, found_key)
//   config   | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// The hash front end works on one beat at a time: 31 remainder steps on the key,
// 7 steps reducing the stride modulo the size, and a push state handing the job over.
// The probe engine then visits p buckets, p from 1 to size, with one memory read
// per cycle unless a result waits on pop; the slower of the two sets the rate.
// After reset a clearing pass writes zero to all TABLE_DEPTH buckets; full stays high
// during it. A result waiting on pop stalls the probe engine; the job queue then fills
// and the front end holds its job, so full stays high.
`default_nettype none
module double_hash_open_address_table_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire dhot_pkg::in_item_t                in_item_i,
  input  wire logic                              pop,
  output logic                                   empty,
  output dhot_pkg::out_item_t                    res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dhot_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dhot_pkg::CFG_W-1:0]        cfg_data_i
);

  dhot_pkg::cfg_t cfg_q;
  dhot_pkg::job_t front_job, fifo_job;
  logic front_busy, front_push, fifo_full, fifo_empty, back_pop, clearing, accept;

  assign full   = front_busy || clearing;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size  <= dhot_pkg::TABLE_SIZE_RST;
      cfg_q.prime <= dhot_pkg::PROBE_PRIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dhot_pkg::REG_TABLE_SIZE:  cfg_q.size  <= cfg_data_i;
        dhot_pkg::REG_PROBE_PRIME: cfg_q.prime <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dhot_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (accept),
    .item_i     (in_item_i),
    .busy_o     (front_busy),
    .job_push_o (front_push),
    .job_o      (front_job),
    .job_full_i (fifo_full)
  );

  dhot_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_job),
    .full_o  (fifo_full),
    .pop_i   (back_pop),
    .empty_o (fifo_empty),
    .rdata_o (fifo_job)
  );

  dhot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (fifo_empty),
    .job_i       (fifo_job),
    .job_pop_o   (back_pop),
    .clearing_o  (clearing),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
